// ----- rtl/signed_integer_to_radix_symbols_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the radix symbol renderer checker
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INTEGER_TO_RADIX_SYMBOLS_MACROS_SVH
`define SIGNED_INTEGER_TO_RADIX_SYMBOLS_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIRS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SIRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sirs_pkg.sv -----
// ----------------------------------------------------------------------------
// sirs_pkg
// Shared constants, register indexes and helpers for the radix renderer.
// ----------------------------------------------------------------------------
package sirs_pkg;

    // default configuration of the renderer
    localparam int MAX_SYMBOLS_DEF = 16;
    localparam int VALUE_BITS_DEF  = 32;

    // fixed field widths
    localparam int RADIX_W  = 5;
    localparam int SYM_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 5;

    // division steps retired per clock
    localparam int DIV_STEPS = 8;

    // register indexes (byte address = 8 * index)
    localparam logic [1:0] REG_RADIX     = 2'd0;
    localparam logic [1:0] REG_SYMS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMS_HIGH = 2'd2;

    // minus sign character
    localparam logic [SYM_W-1:0] MINUS_SIGN = 8'd45;

    // a symbol byte that may not appear in the alphabet
    function automatic logic sym_forbidden(input logic [SYM_W-1:0] c);
        logic bad;
        bad = (c == '0) || (c inside {[8'd32:8'd47], [8'd58:8'd64],
                                      [8'd91:8'd96], [8'd123:8'd126]});
        return bad;
    endfunction

endpackage

// ----- rtl/signed_integer_to_radix_symbols.sv -----
// ----------------------------------------------------------------------------
// signed_integer_to_radix_symbols
// Renders a signed value as symbol bytes in a programmable radix, most
// significant digit first, with a leading minus sign for negative values.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------------------
//  input    | in_valid / in_ready     | value
//  output   | out_valid / out_ready   | symbol, last, alphabet_invalid
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata (pready = 1)
//
// Per value: accept, a check of each symbol in use (fewer on an error), the
// digits one by one on the shared divide unit (8 restoring steps per clock),
// then the minus sign, if any, and the output words, most significant first.
// in_ready is high only while the sequencer is idle; output stalls hold the
// sequencer. Reset clears the registers to 0, which leaves the alphabet invalid.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_symbols
    import sirs_pkg::*;
#(
    parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    // input words
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    // output words
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SYM_W-1:0]   symbol,
    output logic               last,
    output logic               alphabet_invalid
);

    localparam int DIG_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int CPD    = (VALUE_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int DIV_W  = CPD * DIV_STEPS;
    localparam int STEP_W = (CPD > 1) ? $clog2(CPD) : 1;
    localparam int SP_W   = $clog2(VALUE_BITS);
    localparam int CNT_W  = $clog2(VALUE_BITS + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_CHECK  = 6'b000010,
        ST_DIVIDE = 6'b000100,
        ST_SIGN   = 6'b001000,
        ST_DIGITS = 6'b010000,
        ST_ERROR  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [RADIX_W-1:0] radix_reg;
    logic [DATA_W-1:0]  syms_low_reg;
    logic [DATA_W-1:0]  syms_high_reg;

    logic               neg_reg, neg_next;
    logic [DIV_W-1:0]   work_reg, work_next;
    logic [DIG_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DIG_W-1:0]   chk_reg, chk_next;
    logic [CNT_W-1:0]   nd_reg, nd_next;
    logic [DIG_W-1:0]   stack_reg [VALUE_BITS];

    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   symbol_reg, symbol_next;
    logic               last_reg, last_next;
    logic               inv_reg, inv_next;

    logic [SYM_W-1:0]   sym_tab [MAX_SYMBOLS];
    logic               out_free;
    logic               push;
    logic [CNT_W-1:0]   rd_ptr;

    // configuration writes
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg     <= '0;
            syms_low_reg  <= '0;
            syms_high_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                REG_RADIX:     radix_reg     <= pwdata[RADIX_W-1:0];
                REG_SYMS_LOW:  syms_low_reg  <= pwdata;
                REG_SYMS_HIGH: syms_high_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[4:3])
            REG_RADIX:     prdata = DATA_W'(radix_reg);
            REG_SYMS_LOW:  prdata = syms_low_reg;
            REG_SYMS_HIGH: prdata = syms_high_reg;
            default:       prdata = '0;
        endcase
    end

    // alphabet lookup table from the two symbol registers
    always_comb
    begin
        for (int k = 0; k < MAX_SYMBOLS; k++)
        begin
            if (k < 8)
                sym_tab[k] = syms_low_reg[k*SYM_W +: SYM_W];
            else
                sym_tab[k] = syms_high_reg[(k-8)*SYM_W +: SYM_W];
        end
    end

    // alphabet check: radix range, symbol chk_reg against the forbidden bytes and every later symbol in use
    logic             radix_bad;
    logic             sym_bad;
    logic             chk_done;
    logic [SYM_W-1:0] chk_sym;

    assign radix_bad = (radix_reg < RADIX_W'(2)) || (radix_reg > RADIX_W'(MAX_SYMBOLS));
    assign chk_sym   = sym_tab[chk_reg];
    assign chk_done  = (RADIX_W'(chk_reg) + RADIX_W'(1)) == radix_reg;

    always_comb
    begin
        sym_bad = sym_forbidden(chk_sym);
        for (int j = 0; j < MAX_SYMBOLS; j++)
        begin
            if ((RADIX_W'(j) > RADIX_W'(chk_reg)) && (RADIX_W'(j) < radix_reg)
                && (sym_tab[j] == chk_sym))
                sym_bad = 1'b1;
        end
    end

    // shared divide unit: DIV_STEPS restoring steps per clock
    logic [DIG_W:0]   divisor;
    logic [DIV_W-1:0] div_work;
    logic [DIG_W-1:0] div_rem;

    assign divisor = radix_reg[DIG_W:0];

    always_comb
    begin
        logic [DIG_W:0] trial;
        logic [DIG_W:0] diff;
        div_work = work_reg;
        div_rem  = rem_reg;
        for (int s = 0; s < DIV_STEPS; s++)
        begin
            trial    = {div_rem, div_work[DIV_W-1]};
            diff     = trial - divisor;
            div_work = {div_work[DIV_W-2:0], 1'b0};
            if (trial >= divisor)
            begin
                div_rem     = diff[DIG_W-1:0];
                div_work[0] = 1'b1;
            end
            else
            begin
                div_rem = trial[DIG_W-1:0];
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign rd_ptr   = nd_reg - CNT_W'(1);

    // sequencer
    always_comb
    begin
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] mag;
        v              = value[VALUE_BITS-1:0];
        mag            = -v;
        state_next     = state_reg;
        neg_next       = neg_reg;
        work_next      = work_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        chk_next       = chk_reg;
        nd_next        = nd_reg;
        push           = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        inv_next       = inv_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = v[VALUE_BITS-1];
                    work_next  = v[VALUE_BITS-1] ? DIV_W'(mag) : DIV_W'(v);
                    rem_next   = '0;
                    step_next  = '0;
                    chk_next   = '0;
                    nd_next    = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (radix_bad || sym_bad)
                    state_next = ST_ERROR;
                else if (chk_done)
                    state_next = ST_DIVIDE;
                else
                    chk_next = chk_reg + DIG_W'(1);
            end
            ST_DIVIDE:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CPD - 1))
                begin
                    // one digit done: push remainder, restart on quotient
                    push      = 1'b1;
                    nd_next   = nd_reg + CNT_W'(1);
                    rem_next  = '0;
                    step_next = '0;
                    if (div_work == '0)
                        state_next = neg_reg ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = MINUS_SIGN;
                    last_next      = 1'b0;
                    inv_next       = 1'b0;
                    state_next     = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = sym_tab[stack_reg[rd_ptr[SP_W-1:0]]];
                    last_next      = (nd_reg == CNT_W'(1));
                    inv_next       = 1'b0;
                    nd_next        = rd_ptr;
                    if (nd_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            ST_ERROR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    symbol_next    = '0;
                    last_next      = 1'b1;
                    inv_next       = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            nd_reg        <= '0;
            step_reg      <= '0;
            chk_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            nd_reg        <= nd_next;
            step_reg      <= step_next;
            chk_reg       <= chk_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        neg_reg    <= neg_next;
        work_reg   <= work_next;
        rem_reg    <= rem_next;
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        inv_reg    <= inv_next;
        if (push)
            stack_reg[nd_reg[SP_W-1:0]] <= div_rem;
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign symbol           = symbol_reg;
    assign last             = last_reg;
    assign alphabet_invalid = inv_reg;

endmodule

// ----- rtl/sirs_checker.sv -----
// ----------------------------------------------------------------------------
// sirs_checker
// Port-level checks for the radix symbol renderer, bound to the top level.
// ----------------------------------------------------------------------------
`include "signed_integer_to_radix_symbols_macros.svh"

module sirs_checker
    import sirs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [SYM_W-1:0]   symbol,
    input logic               last,
    input logic               alphabet_invalid
);

    // a stalled output word holds its payload
    `SIRS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(symbol) && $stable(last) && $stable(alphabet_invalid), "output word changed while stalled")

    // an error word is a lone zero symbol that closes the value
    `SIRS_ASSERT_SAME(a_err_shape, out_valid && alphabet_invalid, last && (symbol == '0), "malformed error word")

    // a minus sign never closes a value
    `SIRS_ASSERT_SAME(a_sign_not_last, out_valid && !alphabet_invalid && (symbol == MINUS_SIGN), !last, "minus sign marked last")

    // one value at a time: no accept right after an accept
    `SIRS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "input taken while busy")

endmodule

bind signed_integer_to_radix_symbols sirs_checker u_sirs_checker (.*);

// ----- tb/sv/radix_symbols_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix symbol renderer: word checker
// Watches the configuration writes and both word channels. For every value
// taken in it renders the expected symbol words from its own copy of the
// registers, then compares each output word with the oldest expected word.
// ----------------------------------------------------------------------------
module radix_symbols_checker
    import sirs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [VALUE_W-1:0] value,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [SYM_W-1:0]   symbol,
    input  logic               last,
    input  logic               alphabet_invalid,
    output int                 fail_count,
    output int                 pending
);

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
        logic             bad;
    } char_word_t;

    // expected output words, oldest first
    char_word_t char_q[$];

    // shadow copy of the configuration registers
    logic [RADIX_W-1:0] radix_sh;
    logic [DATA_W-1:0]  syms_lo_sh;
    logic [DATA_W-1:0]  syms_hi_sh;

    int errs = 0;

    function automatic logic [SYM_W-1:0] alpha_sym(input int k);
        return (k < 8) ? syms_lo_sh[8*k +: 8] : syms_hi_sh[8*(k-8) +: 8];
    endfunction

    // zero and punctuation bytes may not serve as digits
    function automatic bit byte_allowed(input logic [SYM_W-1:0] c);
        return !((c == 8'd0) ||
                 (c >= 8'd32 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
                 (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126));
    endfunction

    function automatic bit alphabet_usable();
        int n;
        if (radix_sh < 2 || radix_sh > MAX_SYMBOLS_DEF)
            return 1'b0;
        n = radix_sh;
        for (int i = 0; i < n; i++)
        begin
            if (!byte_allowed(alpha_sym(i)))
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (alpha_sym(i) == alpha_sym(j))
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // queue the words that one value renders to
    function automatic void render_expected(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [7:0]         digit [VALUE_W];
        int                 nd;
        char_word_t         w;
        if (!alphabet_usable())
        begin
            w.sym  = '0;
            w.last = 1'b1;
            w.bad  = 1'b1;
            char_q.push_back(w);
            return;
        end
        // two's complement negate; the most negative value maps onto itself
        mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
        nd  = 0;
        do
        begin
            digit[nd] = 8'(mag % radix_sh);
            mag       = mag / radix_sh;
            nd++;
        end
        while (mag != 0);
        if (v[VALUE_W-1])
        begin
            w.sym  = MINUS_SIGN;
            w.last = 1'b0;
            w.bad  = 1'b0;
            char_q.push_back(w);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            w.sym  = alpha_sym(digit[i]);
            w.last = (i == 0);
            w.bad  = 1'b0;
            char_q.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        char_word_t want;
        if (!rst_n)
        begin
            radix_sh   <= '0;
            syms_lo_sh <= '0;
            syms_hi_sh <= '0;
            char_q.delete();
            pending    <= 0;
            fail_count <= errs;
        end
        else
        begin
            // register writes must only happen while the renderer is idle; the renderer does not enforce this
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[ADDR_W-1:3] == REG_RADIX)
                    radix_sh <= pwdata[RADIX_W-1:0];
                else if (paddr[ADDR_W-1:3] == REG_SYMS_LOW)
                    syms_lo_sh <= pwdata;
                else if (paddr[ADDR_W-1:3] == REG_SYMS_HIGH)
                    syms_hi_sh <= pwdata;
            end

            if (in_valid && in_ready)
                render_expected(value);

            if (out_valid && out_ready)
            begin
                if (char_q.size() == 0)
                begin
                    errs++;
                    $display("%0t: unexpected word: symbol %0d last %0d invalid %0d",
                             $time, symbol, last, alphabet_invalid);
                end
                else
                begin
                    want = char_q.pop_front();
                    if (symbol !== want.sym)
                    begin
                        errs++;
                        $display("%0t: symbol mismatch: expected %0d, got %0d",
                                 $time, want.sym, symbol);
                    end
                    if (last !== want.last)
                    begin
                        errs++;
                        $display("%0t: last mismatch: expected %0d, got %0d",
                                 $time, want.last, last);
                    end
                    if (alphabet_invalid !== want.bad)
                    begin
                        errs++;
                        $display("%0t: alphabet_invalid mismatch: expected %0d, got %0d",
                                 $time, want.bad, alphabet_invalid);
                    end
                end
            end

            pending    <= char_q.size();
            fail_count <= errs;
        end
    end

endmodule

// ----- tb/sv/tb_signed_integer_to_radix_symbols.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Radix symbol renderer testbench
// Programs a series of alphabets (valid ones and every way of breaking one),
// renders directed and random values under them with random input gaps and
// output stalls, and reports the word checker's verdict.
// ----------------------------------------------------------------------------
module tb_signed_integer_to_radix_symbols;
    import sirs_pkg::*;

    localparam int LONG_HOLD    = 400;    // receiver hold-off, cycles
    localparam int DRAIN_TAIL   = 200;    // longer than one radix-2 render
    localparam int RANDOM_ITEMS = 280;

    // decimal and hex digit sets, symbol k in byte k
    localparam logic [DATA_W-1:0] DEC_LO = 64'h3736_3534_3332_3130;
    localparam logic [DATA_W-1:0] DEC_HI = 64'h0000_0000_0000_3938;
    localparam logic [DATA_W-1:0] HEX_HI = 64'h4645_4443_4241_3938;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [VALUE_W-1:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [SYM_W-1:0]   symbol;
    logic               last;
    logic               alphabet_invalid;

    int fail_count;
    int pending;
    int hold_count = 0;
    int burst_left = 0;
    int items_sent = 0;

    signed_integer_to_radix_symbols u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .value            (value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .symbol           (symbol),
        .last             (last),
        .alphabet_invalid (alphabet_invalid)
    );

    radix_symbols_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .value            (value),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .symbol           (symbol),
        .last             (last),
        .alphabet_invalid (alphabet_invalid),
        .fail_count       (fail_count),
        .pending          (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // setup cycle, access cycle, then release the bus
    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_alphabet(input logic [RADIX_W-1:0] r,
                                input logic [DATA_W-1:0] lo,
                                input logic [DATA_W-1:0] hi);
        write_reg(REG_RADIX, DATA_W'(r));
        write_reg(REG_SYMS_LOW, lo);
        write_reg(REG_SYMS_HIGH, hi);
    endtask

    // offer one word; bursts of random length with random gaps in between
    task automatic offer_value(input logic [VALUE_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // stop sending and wait for every expected word
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 40);
            1: return -$urandom_range(1, 40);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h7FFF_FFFF;
                    3: return 32'h8000_0000;
                    default: return 32'h8000_0001;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_forbidden();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(32, 47));
            1: return 8'($urandom_range(58, 64));
            2: return 8'($urandom_range(91, 96));
            default: return 8'($urandom_range(123, 126));
        endcase
    endfunction

    // mostly good alphabets; the rest broken in one of the known ways
    task automatic random_alphabet();
        logic [7:0]         syms [16];
        logic [DATA_W-1:0]  lo;
        logic [DATA_W-1:0]  hi;
        logic [RADIX_W-1:0] r;
        logic [7:0]         c;
        bit                 dup;
        int                 kind;
        int                 p;
        int                 q;
        r = RADIX_W'($urandom_range(2, 16));
        for (int k = 0; k < 16; k++)
        begin
            do
            begin
                c   = 8'($urandom_range(1, 255));
                dup = 1'b0;
                for (int j = 0; j < k; j++)
                    if (syms[j] == c)
                        dup = 1'b1;
            end
            while (sym_forbidden(c) || dup);
            syms[k] = c;
            // bytes past the radix are ignored, so anything goes there
            if (k >= r && $urandom_range(0, 1))
                syms[k] = 8'($urandom);
        end
        kind = $urandom_range(0, 11);
        p    = $urandom_range(0, r - 1);
        q    = (p + $urandom_range(1, r - 1)) % r;
        case (kind)
            8:  syms[p] = pick_forbidden();
            9:  syms[q] = syms[p];
            10: syms[p] = 8'd0;
            11: r = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                         : RADIX_W'($urandom_range(17, 31));
            default: ;
        endcase
        for (int k = 0; k < 8; k++)
        begin
            lo[8*k +: 8] = syms[k];
            hi[8*k +: 8] = syms[k + 8];
        end
        set_alphabet(r, lo, hi);
    endtask

    // receiver: changing stall patterns, with a long hold-off on request
    initial
    begin
        int mode;
        int span;
        int hold_seen;
        hold_seen = 0;
        out_ready <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(32, 200);
            for (int i = 0; i < span; i++)
            begin
                @(posedge clk);
                if (hold_count != hold_seen)
                begin
                    hold_seen = hold_count;
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge clk);
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ((i % 8) < 5);
                endcase
            end
        end
    end

    // stimulus
    initial
    begin
        int phase_len;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        value    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: radix zero
        offer_value(32'd5);
        drain();

        // decimal, with the receiver held off while words keep coming
        set_alphabet(5'd10, DEC_LO, DEC_HI);
        hold_count <= hold_count + 1;
        offer_value(32'd0);
        offer_value(32'd7);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h7FFF_FFFF);
        offer_value(32'h8000_0000);
        offer_value(32'd1_000_000_000);
        drain();

        // binary: longest renders
        set_alphabet(5'd2, DEC_LO, DEC_HI);
        offer_value(32'h8000_0000);
        offer_value(32'h7FFF_FFFF);
        offer_value(32'hFFFF_FFFF);
        drain();

        // full sixteen-symbol alphabets, plain and with control/high bytes
        set_alphabet(5'd16, DEC_LO, HEX_HI);
        offer_value(32'hDEAD_BEEF);
        offer_value(32'd0);
        drain();
        set_alphabet(5'd16, 64'h1F7F_80FF_0130_3941, 64'hFEC3_7A61_5A31_1E02);
        offer_value(32'hFFFF_FFFF);
        offer_value(32'h1234_5678);
        drain();

        // radix below two and above the alphabet size
        set_alphabet(5'd1, DEC_LO, DEC_HI);
        offer_value(32'd3);
        drain();
        set_alphabet(5'd31, DEC_LO, HEX_HI);
        offer_value(32'd3);
        drain();

        // punctuation in use: colon, tilde
        set_alphabet(5'd10, 64'h3736_3534_3A32_3130, DEC_HI);
        offer_value(32'd42);
        drain();
        set_alphabet(5'd10, DEC_LO, 64'h0000_0000_0000_7E38);
        offer_value(32'd42);
        drain();

        // repeated symbol, then a zero byte in use
        set_alphabet(5'd10, DEC_LO, 64'h0000_0000_0000_3038);
        offer_value(32'd42);
        drain();
        set_alphabet(5'd3, 64'h0000_0000_0000_3130, 64'h0);
        offer_value(32'd42);
        drain();

        // a forbidden byte just past the radix is harmless
        set_alphabet(5'd3, 64'h0000_0000_2032_3130, 64'h0);
        offer_value(32'hFFFF_FFFB);
        drain();

        // random alphabets and values
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            random_alphabet();
            if ($urandom_range(0, 3) == 0)
                hold_count <= hold_count + 1;
            phase_len = $urandom_range(8, 40);
            if (phase_len > RANDOM_ITEMS - items_sent)
                phase_len = RANDOM_ITEMS - items_sent;
            repeat (phase_len)
                offer_value(pick_value());
            drain();
        end

        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
